// ===== src/pec_pkg.sv =====
// Shared types, constants and the gain table for the peak envelope compressor.
package pec_pkg;

    localparam int MUL_W      = 32;
    localparam int TAB_MAX    = 12;
    localparam int TAB_IDX_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int THR_W      = 23;
    localparam int COEF_W     = 16;
    localparam int GAIN_W     = 16;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd32768;
    localparam logic [THR_W-1:0]  THR_RESET  = 23'h7F_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_SLOPE     = 2'd1,
        CFG_ATTACK    = 2'd2,
        CFG_RELEASE   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold_level;
        logic [COEF_W-1:0] compression_slope;
        logic [COEF_W-1:0] attack_coeff;
        logic [COEF_W-1:0] release_coeff;
    } cfg_t;

    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV_M1,
        ST_ENV_M2,
        ST_ENV_SUM,
        ST_CMP,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_LOG_SQW,
        ST_EXP_M,
        ST_EXP_W,
        ST_G_CHK,
        ST_G_W,
        ST_G_SHIFT,
        ST_OUT_M,
        ST_OUT_W
    } state_t;

    typedef logic [MUL_W-1:0] exp_tab_t [0:TAB_MAX];

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bt;
        rem = n;
        res = 64'd0;
        bt  = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bt) begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end
            else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // T[k] = 2^(-2^-k), Q0.32
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t t;
        t[0] = 32'h8000_0000;
        for (int k = 1; k <= TAB_MAX; k++) begin
            t[k] = MUL_W'(floor_sqrt(64'(t[k-1]) << 32));
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== src/pec_cfg.sv =====
// Configuration register bank for the peak envelope compressor.
module pec_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pec_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pec_pkg::cfg_t                    cfg
);
    import pec_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_level   <= THR_RESET;
            cfg_reg.compression_slope <= '0;
            cfg_reg.attack_coeff      <= '0;
            cfg_reg.release_coeff     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_THRESHOLD: cfg_reg.threshold_level   <= cfg_data[THR_W-1:0];
                CFG_SLOPE:     cfg_reg.compression_slope <= cfg_data[COEF_W-1:0];
                CFG_ATTACK:    cfg_reg.attack_coeff      <= cfg_data[COEF_W-1:0];
                CFG_RELEASE:   cfg_reg.release_coeff     <= cfg_data[COEF_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/pec_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
module pec_mul (
    input  logic                        clk,
    input  pec_pkg::mul_op_t            op,
    output logic [2*pec_pkg::MUL_W-1:0] prod
);
    import pec_pkg::*;

    logic [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            prod_reg <= 64'(op.a) * 64'(op.b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== src/peak_envelope_compressor_core.sv =====
// Top level of the feedforward peak compressor: sequencer and datapath.
// One sample is taken per transfer and gives one result transfer. All products
// run through a single shared 32x32 multiplier under a small sequencer, so the
// block takes one sample at a time: in_ready is high only while the sequencer is
// idle. A sample whose envelope stays at or below the threshold takes two envelope
// products and one output product. A compressed sample adds two log2 evaluations
// (a one-bit-per-cycle normalize plus LOG_TABLE_BITS squaring steps each), one
// exponent product and up to LOG_TABLE_BITS table products. The normalize shifts
// and the shared multiplier set the time per sample. The output register lets the
// next sample enter while a result waits.
module peak_envelope_compressor_core #(
    parameter int SAMPLE_BITS    = 24,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       sample_out,
    output logic [pec_pkg::GAIN_W-1:0]          gain_applied,
    input  logic                                cfg_we,
    input  logic [pec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pec_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pec_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int LTB = LOG_TABLE_BITS;
    localparam int PW = 5;              // log2 integer part, 0..31
    localparam int LW = PW + LTB;       // log2 value width
    localparam logic [SB-1:0] ENV_MAX = SB'(1) << (SB - 1);

    cfg_t    cfg;
    mul_op_t mul_op;
    logic [2*MUL_W-1:0] mul_p;

    pec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pec_mul u_mul (
        .clk  (clk),
        .op   (mul_op),
        .prod (mul_p)
    );

    state_t state_reg, state_next;

    logic [SB-1:0]        env_reg;
    logic [SB-1:0]        mag_reg;
    logic                 neg_reg;
    logic [COEF_W-1:0]    coef_reg;
    logic [2*MUL_W-1:0]   acc_reg;
    logic [MUL_W-1:0]     m_reg;
    logic [PW-1:0]        p_reg;
    logic [LW-1:0]        r_reg;
    logic [LW-1:0]        r_env_reg;
    logic                 log_thr_reg;   // second log pass (threshold)
    logic [TAB_IDX_W-1:0] k_reg;
    logic [PW-1:0]        q_reg;
    logic [LTB-1:0]       f_reg;
    logic [MUL_W:0]       g_reg;         // Q0.32, bit 32 set means unity
    logic [GAIN_W-1:0]    gain_reg;
    logic                 out_valid_reg;
    logic [SB-1:0]        sample_out_reg;
    logic [GAIN_W-1:0]    gain_out_reg;

    // combinational helpers
    logic                 accept;
    logic                 load_out;
    logic [SB-1:0]        in_mag;
    logic [2*MUL_W-1:0]   env_sum;
    logic [MUL_W-1:0]     thr_v;
    logic [MUL_W-1:0]     sq;
    logic                 norm_done;
    logic                 log_last;
    logic                 gain_last;
    logic [LW:0]          l_diff;
    logic [LW-1:0]        l_val;
    logic [LW-1:0]        e_val;
    logic [MUL_W:0]       g_shift;
    logic [SB-1:0]        prod_mag;

    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == ST_OUT_W) && (!out_valid_reg || out_ready);
    assign in_mag   = sample_in[SB-1] ? (~sample_in + SB'(1)) : sample_in;
    assign env_sum  = acc_reg + mul_p + 64'd32768;
    assign thr_v    = (cfg.threshold_level == '0) ? MUL_W'(1)
                                                  : MUL_W'(cfg.threshold_level);
    assign sq        = mul_p[61:30];
    assign norm_done = !m_reg[31] && m_reg[30];
    assign log_last  = (k_reg == TAB_IDX_W'(LTB - 1));
    assign gain_last = (k_reg == TAB_IDX_W'(LTB));
    assign l_diff    = {1'b0, r_env_reg} - {1'b0, r_reg};
    assign l_val     = l_diff[LW] ? '0 : l_diff[LW-1:0];
    assign e_val     = mul_p[LW+15:16];
    assign g_shift   = g_reg >> q_reg;
    assign prod_mag  = mul_p[SB+14:15];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (accept) state_next = ST_ENV_M1;
            ST_ENV_M1:   state_next = ST_ENV_M2;
            ST_ENV_M2:   state_next = ST_ENV_SUM;
            ST_ENV_SUM:  state_next = ST_CMP;
            ST_CMP:      state_next = (MUL_W'(env_reg) > MUL_W'(cfg.threshold_level))
                                      ? ST_LOG_NORM : ST_OUT_M;
            ST_LOG_NORM: if (norm_done) state_next = ST_LOG_SQ;
            ST_LOG_SQ:   state_next = ST_LOG_SQW;
            ST_LOG_SQW:
            begin
                priority if (!log_last) state_next = ST_LOG_SQ;
                else if (log_thr_reg)   state_next = ST_EXP_M;
                else                    state_next = ST_LOG_NORM;
            end
            ST_EXP_M:    state_next = ST_EXP_W;
            ST_EXP_W:    state_next = ST_G_CHK;
            ST_G_CHK:
            begin
                priority if (f_reg[LTB-1] && !g_reg[MUL_W]) state_next = ST_G_W;
                else if (gain_last)                       state_next = ST_G_SHIFT;
                else                                      state_next = ST_G_CHK;
            end
            ST_G_W:      state_next = gain_last ? ST_G_SHIFT : ST_G_CHK;
            ST_G_SHIFT:  state_next = ST_OUT_M;
            ST_OUT_M:    state_next = ST_OUT_W;
            ST_OUT_W:    if (load_out) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake and multiplier operands
    always_comb
    begin
        in_ready  = 1'b0;
        mul_op.en = 1'b0;
        mul_op.a  = '0;
        mul_op.b  = '0;
        unique case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_ENV_M1:
            begin
                mul_op.en = 1'b1;
                mul_op.a  = MUL_W'(coef_reg);
                mul_op.b  = MUL_W'(env_reg);
            end
            ST_ENV_M2:
            begin
                mul_op.en = 1'b1;
                mul_op.a  = MUL_W'(17'h1_0000 - {1'b0, coef_reg});
                mul_op.b  = MUL_W'(mag_reg);
            end
            ST_LOG_SQ:
            begin
                mul_op.en = 1'b1;
                mul_op.a  = m_reg;
                mul_op.b  = m_reg;
            end
            ST_EXP_M:
            begin
                mul_op.en = 1'b1;
                mul_op.a  = MUL_W'(cfg.compression_slope);
                mul_op.b  = MUL_W'(l_val);
            end
            ST_G_CHK:
            begin
                mul_op.en = f_reg[LTB-1] && !g_reg[MUL_W];
                mul_op.a  = g_reg[MUL_W-1:0];
                mul_op.b  = EXP_TAB[k_reg];
            end
            ST_OUT_M:
            begin
                mul_op.en = 1'b1;
                mul_op.a  = MUL_W'(mag_reg);
                mul_op.b  = MUL_W'(gain_reg);
            end
            default:
            begin
                mul_op.en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            env_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ENV_SUM)
            begin
                env_reg <= env_sum[SB+15:16];
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_reg  <= sample_in[SB-1];
                    mag_reg  <= in_mag;
                    coef_reg <= (in_mag > env_reg) ? cfg.attack_coeff : cfg.release_coeff;
                end
            end
            ST_ENV_M2:
                acc_reg <= mul_p;
            ST_CMP:
            begin
                gain_reg    <= UNITY_GAIN;
                m_reg       <= MUL_W'(env_reg);
                p_reg       <= PW'(30);
                log_thr_reg <= 1'b0;
            end
            ST_LOG_NORM:
            begin
                priority if (m_reg[31])
                begin
                    m_reg <= m_reg >> 1;
                    p_reg <= p_reg + PW'(1);
                end
                else if (!m_reg[30])
                begin
                    m_reg <= m_reg << 1;
                    p_reg <= p_reg - PW'(1);
                end
                else
                begin
                    r_reg <= LW'(p_reg);
                    k_reg <= '0;
                end
            end
            ST_LOG_SQW:
            begin
                // squaring step: one fraction bit per pass
                r_reg <= {r_reg[LW-2:0], sq[31]};
                k_reg <= k_reg + TAB_IDX_W'(1);
                if (log_last && !log_thr_reg)
                begin
                    r_env_reg   <= {r_reg[LW-2:0], sq[31]};
                    m_reg       <= thr_v;
                    p_reg       <= PW'(30);
                    log_thr_reg <= 1'b1;
                end
                else
                begin
                    m_reg <= sq[31] ? (sq >> 1) : sq;
                end
            end
            ST_EXP_W:
            begin
                q_reg <= e_val[LW-1:LTB];
                f_reg <= e_val[LTB-1:0];
                g_reg <= {1'b1, {MUL_W{1'b0}}};
                k_reg <= TAB_IDX_W'(1);
            end
            ST_G_CHK:
            begin
                if (!(f_reg[LTB-1] && !g_reg[MUL_W]))
                begin
                    if (f_reg[LTB-1])
                    begin
                        g_reg <= {1'b0, EXP_TAB[k_reg]};   // unity times T[k]
                    end
                    f_reg <= f_reg << 1;
                    k_reg <= k_reg + TAB_IDX_W'(1);
                end
            end
            ST_G_W:
            begin
                g_reg <= {1'b0, mul_p[63:32]};
                f_reg <= f_reg << 1;
                k_reg <= k_reg + TAB_IDX_W'(1);
            end
            ST_G_SHIFT:
                gain_reg <= g_shift[MUL_W:17];
            ST_OUT_W:
            begin
                if (load_out)
                begin
                    sample_out_reg <= neg_reg ? (~prod_mag + SB'(1)) : prod_mag;
                    gain_out_reg   <= gain_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign sample_out   = sample_out_reg;
    assign gain_applied = gain_out_reg;

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gain_applied <= UNITY_GAIN)
        else $error("gain above unity");

    a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
        env_reg <= ENV_MAX)
        else $error("envelope out of range");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while busy");

    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mul_op.en)
        else $error("multiplier issued while idle");

endmodule

// ===== verif/peak_envelope_compressor_core_test.sv =====
// Self-checking testbench for the peak envelope compressor core.
module peak_envelope_compressor_core_test;
    import pec_pkg::*;

    localparam int SB        = 24;
    localparam int TB        = 8;
    localparam int HOLD_LEN  = 400;   // long receiver hold-off, in cycles
    localparam int SETTLE    = 150;   // quiet cycles around config writes and at the end
    localparam int PHASE_LEN = 130;   // random samples per configuration

    typedef struct packed {
        logic [SB-1:0]     smp;
        logic [GAIN_W-1:0] gain;
    } comp_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [SB-1:0]     sample_in = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [SB-1:0]     sample_out;
    logic [GAIN_W-1:0]        gain_applied;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    // Predictor state: its own copy of the registers and the envelope.
    logic [THR_W-1:0]         thr_q;
    logic [COEF_W-1:0]        slope_q;
    logic [COEF_W-1:0]        attack_q;
    logic [COEF_W-1:0]        release_q;
    longint unsigned          env_q;
    longint unsigned          pow_tab [0:TB];

    logic signed [SB-1:0]     samples_pending [$];
    comp_result_t             results_due [$];

    logic                     tx_idle_en = 1'b0;
    logic                     rx_idle_en = 1'b0;
    int                       hold_token = 0;
    int                       tx_gap;
    int                       rx_stall;
    int                       hold_left;
    int                       holds_seen;
    int                       n_sent = 0;
    int                       n_checked = 0;
    int                       n_reduced = 0;
    int                       n_errors = 0;
    int                       n_configs = 1;

    peak_envelope_compressor_core #(
        .SAMPLE_BITS   (SB),
        .LOG_TABLE_BITS(TB)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out),
        .gain_applied(gain_applied),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Bit-serial integer square root, rounded down.
    function automatic longint unsigned isqrt_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    // log2 of v (v >= 1) with TB fraction bits: normalize, then square per bit.
    function automatic longint log2_frac(input longint unsigned v);
        int              msb;
        longint unsigned m;
        longint          r;
        msb = 0;
        for (int i = 0; i < 64; i++)
            if (v[i])
                msb = i;
        m = (msb <= 30) ? (v << (30 - msb)) : (v >> (msb - 30));
        r = msb;
        for (int i = 0; i < TB; i++)
        begin
            m = (m * m) >> 30;
            r = r * 2;
            if (m >= (64'd1 << 31))
            begin
                r = r + 1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    // Envelope update and gain for one sample; advances env_q.
    function automatic comp_result_t compress_sample(input logic signed [SB-1:0] x);
        comp_result_t    res;
        logic            neg;
        longint unsigned mag;
        longint unsigned coef;
        longint unsigned gain;
        longint unsigned g;
        longint unsigned e;
        longint unsigned q;
        longint unsigned prod;
        longint          lg;
        logic [SB-1:0]   p24;
        neg  = x[SB-1];
        mag  = neg ? longint'(-longint'(x)) : longint'(x);
        coef = (mag > env_q) ? attack_q : release_q;
        env_q = (coef * env_q + (65536 - coef) * mag + 32768) >> 16;
        gain = UNITY_GAIN;
        if (env_q > thr_q)
        begin
            lg = log2_frac(env_q) - log2_frac((thr_q == 0) ? 1 : thr_q);
            if (lg < 0)
                lg = 0;
            e = (longint'(slope_q) * lg) >> 16;
            q = e >> TB;
            g = 64'd1 << 32;
            for (int k = 1; k <= TB; k++)
                if (e[TB-k])
                    g = (g * pow_tab[k]) >> 32;
            g = (q >= 64) ? 0 : (g >> q);
            gain = g >> 17;
        end
        prod = (mag * gain) >> 15;
        p24 = prod[SB-1:0];
        res.smp  = neg ? -p24 : p24;
        res.gain = gain[GAIN_W-1:0];
        return res;
    endfunction

    // Sender: pops pending samples, predicts each transfer as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        int gap_now;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            sample_in <= '0;
            tx_gap    <= 0;
        end
        else
        begin
            gap_now = tx_gap;
            if (in_valid && in_ready)
            begin
                results_due.push_back(compress_sample(sample_in));
                n_sent++;
                gap_now = tx_idle_en ? $urandom_range(13, 0) : 0;
            end
            if (in_valid && !in_ready)
                ;   // payload holds until the transfer happens
            else if (gap_now > 0)
            begin
                in_valid <= 1'b0;
                tx_gap   <= gap_now - 1;
            end
            else if (samples_pending.size() > 0)
            begin
                in_valid  <= 1'b1;
                sample_in <= samples_pending.pop_front();
                tx_gap    <= 0;
            end
            else
            begin
                in_valid <= 1'b0;
                tx_gap   <= 0;
            end
        end
    end

    // Receiver: checks each result transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        int           stall_now;
        comp_result_t exp_r;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            rx_stall   <= 0;
            hold_left  <= 0;
            holds_seen <= 0;
        end
        else
        begin
            stall_now = rx_stall;
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result transfer with nothing predicted: sample_out=%0d gain=%0d",
                           sample_out, gain_applied);
                    n_errors++;
                end
                else
                begin
                    exp_r = results_due.pop_front();
                    if (sample_out !== exp_r.smp)
                    begin
                        $error("sample_out: expected %0d, got %0d",
                               $signed(exp_r.smp), sample_out);
                        n_errors++;
                    end
                    if (gain_applied !== exp_r.gain)
                    begin
                        $error("gain_applied: expected %0d, got %0d", exp_r.gain, gain_applied);
                        n_errors++;
                    end
                    if (exp_r.gain != UNITY_GAIN)
                        n_reduced++;
                end
                n_checked++;
                stall_now = rx_idle_en ? $urandom_range(13, 0) : 0;
            end
            // A new hold request freezes the output so the core backs up.
            if (hold_token != holds_seen)
            begin
                holds_seen <= hold_token;
                hold_left  <= HOLD_LEN;
                out_ready  <= 1'b0;
                rx_stall   <= stall_now;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
                rx_stall  <= stall_now;
            end
            else if (stall_now > 0)
            begin
                out_ready <= 1'b0;
                rx_stall  <= stall_now - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                rx_stall  <= 0;
            end
        end
    end

    // Sender pause: wait until everything sent has come back, then let the core settle.
    // Checked on the falling edge so the sender's updates have all landed.
    task automatic drain_all();
        while (samples_pending.size() > 0 || in_valid || results_due.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes all four registers on back-to-back cycles; core must be idle.
    task automatic load_config(input logic [THR_W-1:0] thr, input logic [COEF_W-1:0] slope,
                               input logic [COEF_W-1:0] att, input logic [COEF_W-1:0] rel);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_index <= CFG_SLOPE;
        cfg_data  <= CFG_DATA_W'(slope);
        @(posedge clk);
        cfg_index <= CFG_ATTACK;
        cfg_data  <= CFG_DATA_W'(att);
        @(posedge clk);
        cfg_index <= CFG_RELEASE;
        cfg_data  <= CFG_DATA_W'(rel);
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr_q     = thr;
        slope_q   = slope;
        attack_q  = att;
        release_q = rel;
        n_configs++;
    endtask

    // Register value: zero, full scale or random.
    function automatic int unsigned pick_reg(input int unsigned full);
        case ($urandom_range(3, 0))
            0: return 0;
            1: return full;
            default: return $urandom_range(full, 0);
        endcase
    endfunction

    // Mix of full-scale samples, quieter ones and short loud bursts.
    function automatic logic signed [SB-1:0] pick_sample();
        logic signed [SB-1:0] v;
        v = SB'($urandom);
        case ($urandom_range(3, 0))
            0: return v;
            1: return v >>> $urandom_range(20, 1);
            2: return v[SB-1] ? -24'sd8388608 + SB'($urandom_range(255, 0))
                              : 24'sd8388607 - SB'($urandom_range(255, 0));
            default: return v >>> $urandom_range(8, 4);
        endcase
    endfunction

    initial
    begin
        pow_tab[0] = 64'h8000_0000;
        for (int k = 1; k <= TB; k++)
            pow_tab[k] = isqrt_floor(pow_tab[k-1] << 32);
        thr_q     = THR_RESET;
        slope_q   = '0;
        attack_q  = '0;
        release_q = '0;
        env_q     = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Reset config: full threshold, no compression; sign extremes incl. most negative.
        samples_pending.push_back(24'sd0);
        samples_pending.push_back(24'sd8388607);
        samples_pending.push_back(-24'sd8388608);
        samples_pending.push_back(-24'sd1);
        samples_pending.push_back(24'sd1);
        samples_pending.push_back(24'sd4194304);
        drain_all();

        // Zero threshold with maximum slope: full compression, instant envelope.
        load_config('0, 16'hFFFF, '0, '0);
        samples_pending.push_back(24'sd1);
        samples_pending.push_back(-24'sd1);
        samples_pending.push_back(24'sd8388607);
        samples_pending.push_back(-24'sd8388608);
        samples_pending.push_back(24'sd0);
        samples_pending.push_back(24'sd2);
        drain_all();

        // Slow attack/release: envelope creeps up on a loud tone, then decays.
        load_config(23'h10_0000, 16'h8000, 16'hFFFF, 16'hF000);
        for (int i = 0; i < 8; i++)
            samples_pending.push_back((i % 2) ? -24'sd8388608 : 24'sd8388607);
        for (int i = 0; i < 4; i++)
            samples_pending.push_back(24'sd16);
        drain_all();

        // Random phases under varying configs and flow-control patterns.
        for (int ph = 0; ph < 6; ph++)
        begin
            load_config(THR_W'(pick_reg(23'h7F_FFFF) >> $urandom_range(6, 0)),
                        COEF_W'(pick_reg(16'hFFFF)), COEF_W'(pick_reg(16'hFFFF)),
                        COEF_W'(pick_reg(16'hFFFF)));
            @(posedge clk);
            tx_idle_en <= (ph % 3) != 0;
            rx_idle_en <= (ph % 3) != 1;
            if (ph == 2)
                hold_token <= hold_token + 1;   // receiver stops while the sender keeps going
            for (int i = 0; i < PHASE_LEN; i++)
                samples_pending.push_back(pick_sample());
            drain_all();
        end

        $display("Checked %0d results from %0d samples over %0d register settings;",
                 n_checked, n_sent, n_configs);
        $display("%0d had gain below unity.", n_reduced);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
